// ===== rtl/rf_key_frame_checker_defines.svh =====
// ----------------------------------------------------------------------------
// rf_key_frame_checker_defines
// Assertion macros shared by the key frame checker RTL.
// ----------------------------------------------------------------------------
`ifndef RF_KEY_FRAME_CHECKER_DEFINES_SVH
`define RF_KEY_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define RKFC_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rkfc assertion failed");

// next-cycle implication
`define RKFC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rkfc assertion failed");

`endif

// ===== rtl/rkfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rkfc_pkg
// Types, constants and the CRC-16 helper for the key frame checker.
// ----------------------------------------------------------------------------
package rkfc_pkg;

   localparam int ANTENNA_COUNT_DEF = 4;
   localparam int SAMPLE_DEPTH_DEF  = 5;

   localparam int FRAME_BITS  = 24;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [7:0] ANT_HDR_FIRST = 8'hA2;
   localparam logic [7:0] ANT_HDR_LAST  = 8'hA5;

   localparam logic [15:0] DUP_WINDOW_RST = 16'd80;
   localparam logic [7:0]  KEY_HEADER_RST = 8'h84;
   localparam logic [7:0]  UNLOCK_RST     = 8'h63;
   localparam logic [7:0]  LOCK_RST       = 8'h62;

   typedef enum logic [2:0] {
      ST_KEY_CRC_FAIL   = 3'd0,
      ST_OTHER_CRC_FAIL = 3'd1,
      ST_UNLOCK         = 3'd2,
      ST_LOCK           = 3'd3,
      ST_UNKNOWN_CMD    = 3'd4,
      ST_RSSI_STORED    = 3'd5,
      ST_RSSI_DUP       = 3'd6,
      ST_UNRECOGNIZED   = 3'd7
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DUP_WINDOW = 4'd0,
      CSR_KEY_HEADER = 4'd1,
      CSR_UNLOCK     = 4'd2,
      CSR_LOCK       = 4'd3
   } csr_index_type;

   // one antenna table entry
   typedef struct packed {
      logic [15:0] level;
      logic [31:0] seen_ms;
      logic [2:0]  count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // frame classification handed from decode to the table update
   typedef struct packed {
      status_type  status;
      logic        is_rssi;
      logic [1:0]  ant_off;
   } decode_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  antenna_number;
      logic [15:0] rssi_value;
      logic [2:0]  sample_count;
   } result_type;

   // bit-serial crc, msb first; only evaluated at elaboration
   function automatic logic [15:0] crc_serial(input logic [FRAME_BITS-1:0] data,
                                             input logic [15:0] init);
      logic [15:0] crc;
      logic        fb;
      crc = init;
      for (int k = FRAME_BITS - 1; k >= 0; k--) begin
         fb  = crc[15] ^ data[k];
         crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return crc;
   endfunction

endpackage

// ===== rtl/rkfc_ram.sv =====
// ----------------------------------------------------------------------------
// rkfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rkfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rkfc_decode.sv =====
// ----------------------------------------------------------------------------
// rkfc_decode
// CRC check over the first three frame bytes and frame classification.
// ----------------------------------------------------------------------------
module rkfc_decode #(
   parameter int ANTENNA_COUNT = rkfc_pkg::ANTENNA_COUNT_DEF
) (
   input  logic                   [7:0] header_byte,
   input  logic                   [7:0] payload_low,
   input  logic                   [7:0] payload_high,
   input  logic                   [7:0] check_low,
   input  logic                   [7:0] check_high,
   input  logic                   [7:0] key_header,
   input  logic                   [7:0] unlock_code,
   input  logic                   [7:0] lock_code,
   output rkfc_pkg::decode_type         dec
);

   localparam int NB = rkfc_pkg::FRAME_BITS;
   // crc is linear: init contribution plus one column per set data bit
   localparam logic [15:0] CRC_BASE = rkfc_pkg::crc_serial('0, rkfc_pkg::CRC_INIT);

   logic [NB-1:0] frame_bits;
   logic [15:0]   crc_term [NB];
   logic [15:0]   crc;
   logic          crc_ok;
   logic          is_key;
   logic          in_hdr_range;
   logic [7:0]    hdr_off;
   logic          in_count;

   assign frame_bits = {header_byte, payload_low, payload_high};

   for (genvar i = 0; i < NB; i++) begin : g_col
      localparam logic [NB-1:0] ONE_BIT = NB'(1) << i;
      localparam logic [15:0]   COL     = rkfc_pkg::crc_serial(ONE_BIT, 16'h0000);
      assign crc_term[i] = frame_bits[i] ? COL : 16'h0000;
   end

   always_comb begin
      crc = CRC_BASE;
      for (int i = 0; i < NB; i++) begin
         crc = crc ^ crc_term[i];
      end
   end

   assign crc_ok       = (crc == {check_high, check_low});
   assign is_key       = (header_byte == key_header);
   assign in_hdr_range = (header_byte >= rkfc_pkg::ANT_HDR_FIRST) &&
                         (header_byte <= rkfc_pkg::ANT_HDR_LAST);
   assign hdr_off      = header_byte - rkfc_pkg::ANT_HDR_FIRST;
   assign in_count     = ({1'b0, hdr_off[1:0]} < 3'(ANTENNA_COUNT));

   always_comb begin
      dec.is_rssi = 1'b0;
      dec.ant_off = hdr_off[1:0];
      if (!crc_ok) begin
         dec.status = is_key ? rkfc_pkg::ST_KEY_CRC_FAIL : rkfc_pkg::ST_OTHER_CRC_FAIL;
      end else if (is_key) begin
         // unlock is tested before lock
         if (payload_low == unlock_code) begin
            dec.status = rkfc_pkg::ST_UNLOCK;
         end else if (payload_high == lock_code) begin
            dec.status = rkfc_pkg::ST_LOCK;
         end else begin
            dec.status = rkfc_pkg::ST_UNKNOWN_CMD;
         end
      end else if (in_hdr_range && in_count) begin
         dec.status  = rkfc_pkg::ST_RSSI_STORED;
         dec.is_rssi = 1'b1;
      end else begin
         dec.status = rkfc_pkg::ST_UNRECOGNIZED;
      end
   end

endmodule

// ===== rtl/rkfc_update.sv =====
// ----------------------------------------------------------------------------
// rkfc_update
// Duplicate test and new antenna entry for one rssi item, plus result fields.
// ----------------------------------------------------------------------------
module rkfc_update #(
   parameter int SAMPLE_DEPTH = rkfc_pkg::SAMPLE_DEPTH_DEF
) (
   input  rkfc_pkg::decode_type        dec,
   input  logic                 [15:0] rssi,
   input  logic                 [31:0] now_ms,
   input  rkfc_pkg::entry_type         cur,
   input  logic                        present,
   input  logic                 [15:0] dup_window_ms,
   output logic                        wr_req,
   output rkfc_pkg::entry_type         nxt,
   output rkfc_pkg::result_type        res
);

   logic [31:0] age_ms;
   logic        dup;

   // modulo 2^32 elapsed time
   assign age_ms = now_ms - cur.seen_ms;
   assign dup    = present && (cur.level == rssi) && (age_ms <= {16'h0000, dup_window_ms});
   assign wr_req = dec.is_rssi;

   always_comb begin
      nxt.seen_ms = now_ms;
      if (dup) begin
         nxt.level = cur.level;
         nxt.count = cur.count;
      end else begin
         nxt.level = rssi;
         nxt.count = (cur.count < 3'(SAMPLE_DEPTH)) ? cur.count + 3'd1 : cur.count;
      end
   end

   always_comb begin
      if (dec.is_rssi) begin
         res.status         = dup ? rkfc_pkg::ST_RSSI_DUP : rkfc_pkg::ST_RSSI_STORED;
         res.antenna_number = {1'b0, dec.ant_off} + 3'd1;
         res.rssi_value     = rssi;
         res.sample_count   = nxt.count;
      end else begin
         res.status         = dec.status;
         res.antenna_number = 3'd0;
         res.rssi_value     = 16'h0000;
         res.sample_count   = 3'd0;
      end
   end

endmodule

// ===== rtl/rf_key_frame_checker.sv =====
// ----------------------------------------------------------------------------
// rf_key_frame_checker
// Radio key frame CRC check, command decode and per-antenna RSSI tracking.
// ----------------------------------------------------------------------------
// Takes one frame per clock while req_stall is low and returns one result item
// per frame through the update stage and the output register. The CRC and
// decode are done in the accept cycle while the antenna entry is read from a
// small RAM; the update stage does the duplicate test and writes the entry back
// as it advances. An entry written in the cycle a following frame reads the
// same antenna is forwarded, so back-to-back frames for one antenna see each
// other's updates. Per-entry valid bits give the zero state right after reset
// with no clearing pass. Configuration writes are taken whenever reset is low
// (csr_ready is high) and must only be made while no frame is in flight.
module rf_key_frame_checker #(
   parameter int ANTENNA_COUNT = rkfc_pkg::ANTENNA_COUNT_DEF,
   parameter int SAMPLE_DEPTH  = rkfc_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_header_byte,
   input  logic [7:0]                          req_payload_low,
   input  logic [7:0]                          req_payload_high,
   input  logic [7:0]                          req_check_low,
   input  logic [7:0]                          req_check_high,
   input  logic [31:0]                         req_time_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_frame_status,
   output logic [2:0]                          rsp_antenna_number,
   output logic [15:0]                         rsp_rssi_value,
   output logic [2:0]                          rsp_sample_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rkfc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rkfc_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int ADDR_W = (ANTENNA_COUNT > 1) ? $clog2(ANTENNA_COUNT) : 1;

   // configuration
   logic [15:0] dup_window_ff, dup_window_in;
   logic [7:0]  key_header_ff, key_header_in;
   logic [7:0]  unlock_ff, unlock_in;
   logic [7:0]  lock_ff, lock_in;

   // accept stage
   rkfc_pkg::decode_type dec;
   logic                 accept;
   logic [ADDR_W-1:0]    rd_addr;

   // update stage
   logic                 s1_valid_ff, s1_valid_in;
   rkfc_pkg::decode_type s1_dec_ff;
   logic [15:0]          s1_rssi_ff;
   logic [31:0]          s1_time_ff;
   logic [ADDR_W-1:0]    s1_addr_ff;
   logic                 s1_adv;
   logic                 byp_hit_ff, byp_hit_in;
   rkfc_pkg::entry_type  byp_entry_ff;

   logic [ANTENNA_COUNT-1:0] present_ff, present_in;

   logic [rkfc_pkg::ENTRY_W-1:0] ram_rd_data;
   rkfc_pkg::entry_type          cur_entry;
   logic                         cur_present;
   rkfc_pkg::entry_type          nxt_entry;
   logic                         wr_req;
   logic                         ram_wr_en;
   rkfc_pkg::result_type         res;

   // output register
   logic                 out_valid_ff, out_valid_in;
   rkfc_pkg::result_type out_ff;

   // ---------------------------------------------------------------- config
   assign csr_ready = !reset;

   always_comb begin
      dup_window_in = dup_window_ff;
      key_header_in = key_header_ff;
      unlock_in     = unlock_ff;
      lock_in       = lock_ff;
      if (csr_valid && csr_ready) begin
         case (rkfc_pkg::csr_index_type'(csr_index))
            rkfc_pkg::CSR_DUP_WINDOW: dup_window_in = csr_data;
            rkfc_pkg::CSR_KEY_HEADER: key_header_in = csr_data[7:0];
            rkfc_pkg::CSR_UNLOCK:     unlock_in     = csr_data[7:0];
            rkfc_pkg::CSR_LOCK:       lock_in       = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dup_window_ff <= rkfc_pkg::DUP_WINDOW_RST;
         key_header_ff <= rkfc_pkg::KEY_HEADER_RST;
         unlock_ff     <= rkfc_pkg::UNLOCK_RST;
         lock_ff       <= rkfc_pkg::LOCK_RST;
      end else begin
         dup_window_ff <= dup_window_in;
         key_header_ff <= key_header_in;
         unlock_ff     <= unlock_in;
         lock_ff       <= lock_in;
      end
   end

   // ---------------------------------------------------------------- accept
   rkfc_decode #(
      .ANTENNA_COUNT (ANTENNA_COUNT)
   ) u_decode (
      .header_byte  (req_header_byte),
      .payload_low  (req_payload_low),
      .payload_high (req_payload_high),
      .check_low    (req_check_low),
      .check_high   (req_check_high),
      .key_header   (key_header_ff),
      .unlock_code  (unlock_ff),
      .lock_code    (lock_ff),
      .dec          (dec)
   );

   assign s1_adv    = !out_valid_ff || !rsp_stall;
   assign req_stall = reset || (s1_valid_ff && !s1_adv);
   assign accept    = req_valid && !req_stall;
   assign rd_addr   = dec.ant_off[ADDR_W-1:0];

   // the entry being written at this edge is not yet visible in the ram read
   assign byp_hit_in = ram_wr_en && dec.is_rssi && (s1_addr_ff == rd_addr);

   rkfc_ram #(
      .WIDTH (rkfc_pkg::ENTRY_W),
      .DEPTH (ANTENNA_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (nxt_entry),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- update
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         byp_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            byp_hit_ff <= byp_hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_dec_ff    <= dec;
         s1_rssi_ff   <= {req_payload_high, req_payload_low};
         s1_time_ff   <= req_time_ms;
         s1_addr_ff   <= rd_addr;
         byp_entry_ff <= nxt_entry;
      end
   end

   assign cur_present = present_ff[s1_addr_ff] || byp_hit_ff;

   // an entry never written reads as zero
   always_comb begin
      if (byp_hit_ff) begin
         cur_entry = byp_entry_ff;
      end else if (present_ff[s1_addr_ff]) begin
         cur_entry = rkfc_pkg::entry_type'(ram_rd_data);
      end else begin
         cur_entry = '0;
      end
   end

   rkfc_update #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_update (
      .dec           (s1_dec_ff),
      .rssi          (s1_rssi_ff),
      .now_ms        (s1_time_ff),
      .cur           (cur_entry),
      .present       (cur_present),
      .dup_window_ms (dup_window_ff),
      .wr_req        (wr_req),
      .nxt           (nxt_entry),
      .res           (res)
   );

   assign ram_wr_en = s1_valid_ff && s1_adv && wr_req;

   always_comb begin
      present_in = present_ff;
      if (ram_wr_en) begin
         present_in[s1_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else begin
         present_ff <= present_in;
      end
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      if (s1_valid_ff && s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_adv) begin
         out_ff <= res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_frame_status   = out_ff.status;
   assign rsp_antenna_number = out_ff.antenna_number;
   assign rsp_rssi_value     = out_ff.rssi_value;
   assign rsp_sample_count   = out_ff.sample_count;

   // ---------------------------------------------------------------- checks
`include "rf_key_frame_checker_defines.svh"

   `RKFC_ASSERT(a_stall_only_when_full, req_stall, s1_valid_ff)
   `RKFC_ASSERT(a_write_on_advance, ram_wr_en, s1_valid_ff && s1_adv && s1_dec_ff.is_rssi)
   `RKFC_ASSERT(a_bypass_rssi_only, s1_valid_ff && byp_hit_ff, s1_dec_ff.is_rssi)
   `RKFC_ASSERT(a_count_bound, out_valid_ff, out_ff.sample_count <= 3'(SAMPLE_DEPTH))
   `RKFC_ASSERT_NEXT(a_written_entry_present, ram_wr_en, present_ff != '0)

endmodule
